[hdl/tdpt_pkg.sv]
`timescale 1ns / 1ps

package tdpt_pkg;

    // Table geometry and value width
    localparam int TABLE_DEPTH  = 1024;
    localparam int VALUE_BITS   = 24;
    localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS   = $clog2(TABLE_DEPTH + 1);
    localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

    // Seed entry of the table
    localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);

    // Operation codes
    typedef enum logic [1:0] {
        OP_TEST   = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DECIDED      = 2'd0,
        ST_UNDETERMINED = 2'd1,
        ST_FULL         = 2'd2
    } t_status;

endpackage

[hdl/tdpt_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module tdpt_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]    i_dividend,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]    i_divisor,
    output logic                               o_done,
    output logic [tdpt_pkg::VALUE_BITS-1:0]    o_remainder
);
    import tdpt_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [VALUE_BITS-1:0]   r_rem;
    logic [VALUE_BITS-1:0]   r_quo;
    logic [VALUE_BITS-1:0]   r_div;

    logic [VALUE_BITS:0]     w_shift;
    logic [VALUE_BITS:0]     w_diff;
    logic [VALUE_BITS-1:0]   n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_quo[VALUE_BITS-1]};
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_diff[VALUE_BITS] ? w_shift[VALUE_BITS-1:0] : w_diff[VALUE_BITS-1:0];
    end

    // Step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

[hdl/trial_division_prime_table.sv]
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_stall    i_op, i_candidate
// output    o_valid / i_stall    o_answer, o_status, o_prime_count
//
// One item at a time. Test and insert walk the prime memory: each stored prime
// is read, squared and compared with the candidate, and then divided into it
// when the square does not settle it. A lookup reads and compares each entry.
// Op 3, and test or insert of a candidate below 2, skip the walk.
// Reset is synchronous; entry 0 reads as 2 without being written.
// A result waits in the output register while i_stall is high; the next
// transfer is taken once the finished result has room there.
module trial_division_prime_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_op,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]     i_candidate,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_answer,
    output logic [1:0]                          o_status,
    output logic [tdpt_pkg::COUNT_BITS-1:0]     o_prime_count
);
    import tdpt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_CHECK = 6'b000100,
        S_SQ    = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic [VALUE_BITS-1:0]   r_cand;
    logic [COUNT_BITS-1:0]   r_idx;
    logic [COUNT_BITS-1:0]   r_count;
    logic [VALUE_BITS-1:0]   r_last;
    logic [VALUE_BITS-1:0]   r_p;
    logic [2*VALUE_BITS-1:0] r_sq;
    logic                    r_ans;
    t_status                 r_status;

    logic                    r_out_valid;
    logic                    r_out_answer;
    logic [1:0]              r_out_status;
    logic [COUNT_BITS-1:0]   r_out_count;

    // Prime memory
    logic [VALUE_BITS-1:0]   mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]   r_rd_data;
    logic                    r_rd_zero;
    logic [ADDR_BITS-1:0]    w_addr;
    logic                    w_we;
    logic [VALUE_BITS-1:0]   w_p;

    logic                    w_div_start;
    logic                    w_div_done;
    logic [VALUE_BITS-1:0]   w_div_rem;
    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_is_prime;

    assign w_in_xfer  = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_prime = (r_sq > {{VALUE_BITS{1'b0}}, r_cand});

    // Append happens in the square state for a rising prime with room left
    assign w_we = (r_state == S_SQ) && w_is_prime && (r_op == OP_INSERT)
                  && (r_count < COUNT_BITS'(TABLE_DEPTH)) && (r_cand > r_last);
    assign w_addr      = w_we ? r_count[ADDR_BITS-1:0] : r_idx[ADDR_BITS-1:0];
    assign w_div_start = (r_state == S_SQ) && !w_is_prime;

    // Entry 0 reads as the seed prime and is never written
    assign w_p = r_rd_zero ? FIRST_PRIME : r_rd_data;

    // Memory port: one address per cycle, written when w_we is set and read always, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= r_cand;
        end
        r_rd_data <= mem[w_addr];
        r_rd_zero <= (w_addr == '0);
    end

    tdpt_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_cand),
        .i_divisor   (r_p),
        .o_done      (w_div_done),
        .o_remainder (w_div_rem)
    );

    // Walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= COUNT_BITS'(1);
            r_last  <= FIRST_PRIME;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op     <= t_op'(i_op);
                        r_cand   <= i_candidate;
                        r_idx    <= '0;
                        r_ans    <= 1'b0;
                        r_status <= ST_DECIDED;
                        if (t_op'(i_op) == OP_NONE) begin
                            r_state <= S_FIN;
                        end else if (t_op'(i_op) != OP_LOOKUP && i_candidate < FIRST_PRIME) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    // walk ran past the stored primes
                    if (r_idx >= r_count) begin
                        r_ans    <= 1'b0;
                        r_status <= (r_op == OP_LOOKUP) ? ST_DECIDED : ST_UNDETERMINED;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_op == OP_LOOKUP) begin
                        if (w_p == r_cand) begin
                            r_ans   <= 1'b1;
                            r_state <= S_FIN;
                        end else if (w_p > r_cand) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end else if (w_p == '0) begin
                        r_status <= ST_UNDETERMINED;
                        r_state  <= S_FIN;
                    end else begin
                        r_p     <= w_p;
                        r_sq    <= w_p * w_p;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_is_prime) begin
                        r_ans <= 1'b1;
                        if (r_op == OP_INSERT && r_count >= COUNT_BITS'(TABLE_DEPTH)) begin
                            r_status <= ST_FULL;
                        end
                        if (w_we) begin
                            r_count <= r_count + 1'b1;
                            r_last  <= r_cand;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_div_rem == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_answer <= r_ans;
                r_out_status <= r_status;
                r_out_count  <= r_count;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_answer      = r_out_answer;
    assign o_status      = r_out_status;
    assign o_prime_count = r_out_count;

endmodule
